[design/lz10_pkg.sv]
package lz10_pkg;

   // history window
   localparam int WINDOW_DEPTH = 4096;
   localparam int HIST_AW = $clog2(WINDOW_DEPTH);

   // pair format: length nibble over a 12-bit distance
   localparam int DIST_W = 12;
   localparam int PROD_W = DIST_W + 1;
   localparam logic [PROD_W-1:0] PROD_MAX = PROD_W'(1 << DIST_W);
   localparam int LEN_W = 5;
   localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);

   // stream header
   localparam logic [7:0] VERSION_ID = 8'h10;
   localparam int SIZE_W = 24;

   // error codes on the result side
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_DISTANCE = 2'd2;

   // command queue
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = CMD_AW + 1;
   localparam logic [CMD_CNT_W-1:0] CMD_FULL = CMD_CNT_W'(CMD_DEPTH);

   typedef enum logic [1:0] {
      CMD_LIT  = 2'd0,
      CMD_COPY = 2'd1,
      CMD_ERR  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         data;
      logic [1:0]         err;
      logic [LEN_W-1:0]   count;
      logic [DIST_W-1:0]  dist_m1;
      logic [HIST_AW-1:0] wpos;
      logic               done;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

[design/lz10_front.sv]
module lz10_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // in_byte
   input  logic                     req_tuser,   // start_req
   input  lz10_pkg::fifo_status_type fifo_status,
   output logic                     cmd_push,
   output lz10_pkg::cmd_type        cmd
);
   import lz10_pkg::*;

   typedef enum logic [4:0] {
      PH_FINISHED = 5'b00001,
      PH_HEADER   = 5'b00010,
      PH_CONTROL  = 5'b00100,
      PH_DATA     = 5'b01000,
      PH_PAIR_LOW = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [1:0]         hidx_ff, hidx_in;
   logic [SIZE_W-1:0]  remaining_ff, remaining_in;
   logic [PROD_W-1:0]  produced_ff, produced_in;
   logic [HIST_AW-1:0] wpos_ff, wpos_in;
   logic [7:0]         flags_ff, flags_in;
   logic [2:0]         bit_ff, bit_in;
   logic [7:0]         pair_ff, pair_in;

   logic               accept;
   logic               do_finish;
   logic [DIST_W-1:0]  dist_m1;
   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   take;
   logic [PROD_W-1:0]  prod_sum;

   assign req_tready = !fifo_status.full;
   assign accept = req_tvalid && req_tready;

   // pair decode
   assign dist_m1 = {pair_ff[3:0], req_tdata};
   assign len = {1'b0, pair_ff[7:4]} + LEN_BIAS;

   // parser
   always_comb begin
      phase_in = phase_ff;
      hidx_in = hidx_ff;
      remaining_in = remaining_ff;
      produced_in = produced_ff;
      wpos_in = wpos_ff;
      flags_in = flags_ff;
      bit_in = bit_ff;
      pair_in = pair_ff;
      cmd_push = 1'b0;
      cmd = '0;
      do_finish = 1'b0;
      take = '0;
      prod_sum = '0;
      if (accept) begin
         if (req_tuser) begin
            wpos_in = '0;
            produced_in = '0;
            remaining_in = '0;
            flags_in = '0;
            bit_in = 3'd7;
            pair_in = '0;
            hidx_in = 2'd1;
            if (req_tdata != VERSION_ID) begin
               phase_in = PH_FINISHED;
               cmd_push = 1'b1;
               cmd.kind = CMD_ERR;
               cmd.err = ERR_VERSION;
            end else begin
               phase_in = PH_HEADER;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  unique case (hidx_ff)
                     2'd1: remaining_in[7:0] = remaining_ff[7:0] | req_tdata;
                     2'd2: remaining_in[15:8] = remaining_ff[15:8] | req_tdata;
                     2'd3: remaining_in[23:16] = remaining_ff[23:16] | req_tdata;
                     default: remaining_in = remaining_ff;
                  endcase
                  if (hidx_ff == 2'd3) begin
                     hidx_in = 2'd0;
                     phase_in = (remaining_in == '0) ? PH_FINISHED : PH_CONTROL;
                  end else begin
                     hidx_in = hidx_ff + 2'd1;
                  end
               end
               PH_CONTROL: begin
                  flags_in = req_tdata;
                  bit_in = 3'd7;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (flags_ff[bit_ff]) begin
                     pair_in = req_tdata;
                     phase_in = PH_PAIR_LOW;
                  end else begin
                     take = LEN_W'(1);
                     do_finish = 1'b1;
                     cmd_push = 1'b1;
                     cmd.kind = CMD_LIT;
                     cmd.data = req_tdata;
                     cmd.wpos = wpos_ff;
                  end
               end
               PH_PAIR_LOW: begin
                  if ({1'b0, dist_m1} >= produced_ff) begin
                     phase_in = PH_FINISHED;
                     cmd_push = 1'b1;
                     cmd.kind = CMD_ERR;
                     cmd.err = ERR_DISTANCE;
                  end else begin
                     // cut the copy at the declared size
                     take = (remaining_ff < SIZE_W'(len)) ? remaining_ff[LEN_W-1:0] : len;
                     do_finish = 1'b1;
                     cmd_push = 1'b1;
                     cmd.kind = CMD_COPY;
                     cmd.count = take;
                     cmd.dist_m1 = dist_m1;
                     cmd.wpos = wpos_ff;
                  end
               end
               PH_FINISHED: begin
                  phase_in = PH_FINISHED;
               end
               default: phase_in = PH_FINISHED;
            endcase
         end
      end

      // bookkeeping after a literal or a copy
      if (do_finish) begin
         remaining_in = remaining_ff - SIZE_W'(take);
         prod_sum = produced_ff + PROD_W'(take);
         produced_in = (prod_sum > PROD_MAX) ? PROD_MAX : prod_sum;
         wpos_in = wpos_ff + HIST_AW'(take);
         cmd.done = (remaining_in == '0);
         if (remaining_in == '0) begin
            phase_in = PH_FINISHED;
         end else if (bit_ff == 3'd0) begin
            phase_in = PH_CONTROL;
         end else begin
            bit_in = bit_ff - 3'd1;
            phase_in = PH_DATA;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FINISHED;
         hidx_ff <= '0;
         remaining_ff <= '0;
         produced_ff <= '0;
         wpos_ff <= '0;
         flags_ff <= '0;
         bit_ff <= 3'd7;
         pair_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         hidx_ff <= hidx_in;
         remaining_ff <= remaining_in;
         produced_ff <= produced_in;
         wpos_ff <= wpos_in;
         flags_ff <= flags_in;
         bit_ff <= bit_in;
         pair_ff <= pair_in;
      end
   end

endmodule

[design/lz10_cmd_fifo.sv]
module lz10_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lz10_pkg::cmd_type         push_cmd,
   input  logic                      pop,
   output lz10_pkg::cmd_type         head_cmd,
   output lz10_pkg::fifo_status_type status
);
   import lz10_pkg::*;

   cmd_type               entries_ff [CMD_DEPTH];
   logic [CMD_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CMD_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign status.full = (cnt_ff == CMD_FULL);
   assign status.empty = (cnt_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_AW'(1) : rd_ptr_ff;
      cnt_in = cnt_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/lz10_back.sv]
module lz10_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lz10_pkg::fifo_status_type fifo_status,
   input  lz10_pkg::cmd_type         head_cmd,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // out_byte
   output logic                      rsp_tlast,   // last_of_run
   output logic [2:0]                rsp_tuser    // done_res, error[1:0]
);
   import lz10_pkg::*;

   typedef enum logic [2:0] {
      BK_IDLE   = 3'b001,
      BK_SINGLE = 3'b010,
      BK_COPY   = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [HIST_AW-1:0] src_ff, src_in;
   logic [HIST_AW-1:0] wr_ff, wr_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic               dvld_ff, dvld_in;
   logic [7:0]         rd_data_ff;
   logic [7:0]         hist_mem [WINDOW_DEPTH];

   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_last_ff;
   logic [2:0]         rsp_user_ff;

   logic               out_free;
   logic               emit;
   logic [7:0]         e_byte;
   logic               e_last;
   logic               e_done;
   logic [1:0]         e_err;
   logic               we;
   logic [HIST_AW-1:0] wa;
   logic [7:0]         wd;
   logic               rd_en;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // command execution
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      src_in = src_ff;
      wr_in = wr_ff;
      rem_in = rem_ff;
      dvld_in = dvld_ff;
      pop = 1'b0;
      emit = 1'b0;
      e_byte = '0;
      e_last = 1'b0;
      e_done = 1'b0;
      e_err = ERR_NONE;
      we = 1'b0;
      wa = wr_ff;
      wd = rd_data_ff;
      rd_en = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               pop = 1'b1;
               cur_in = head_cmd;
               if (head_cmd.kind == CMD_COPY) begin
                  state_in = BK_COPY;
                  src_in = head_cmd.wpos - HIST_AW'(head_cmd.dist_m1) - HIST_AW'(1);
                  wr_in = head_cmd.wpos;
                  rem_in = head_cmd.count;
                  dvld_in = 1'b0;
               end else begin
                  state_in = BK_SINGLE;
               end
            end
         end
         BK_SINGLE: begin
            if (out_free) begin
               emit = 1'b1;
               e_last = 1'b1;
               if (cur_ff.kind == CMD_LIT) begin
                  e_byte = cur_ff.data;
                  e_done = cur_ff.done;
                  we = 1'b1;
                  wa = cur_ff.wpos;
                  wd = cur_ff.data;
               end else begin
                  e_err = cur_ff.err;
               end
               state_in = BK_IDLE;
            end
         end
         BK_COPY: begin
            // one history byte per beat, next read overlaps the write
            emit = dvld_ff && out_free;
            rd_en = !dvld_ff || (emit && rem_ff != LEN_W'(1));
            if (rd_en) begin
               src_in = src_ff + HIST_AW'(1);
            end
            if (emit) begin
               e_byte = rd_data_ff;
               e_last = (rem_ff == LEN_W'(1));
               e_done = cur_ff.done && (rem_ff == LEN_W'(1));
               we = 1'b1;
               wa = wr_ff;
               wd = rd_data_ff;
               wr_in = wr_ff + HIST_AW'(1);
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
            dvld_in = rd_en ? 1'b1 : (emit ? 1'b0 : dvld_ff);
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // history memory, read with write bypass for distance one
   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= (we && wa == src_ff) ? wd : hist_mem[src_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         dvld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dvld_ff <= dvld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      src_ff <= src_in;
      wr_ff <= wr_in;
      rem_ff <= rem_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= e_byte;
         rsp_last_ff <= e_last;
         rsp_user_ff <= {e_err, e_done};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

[design/lz10_stream_decompressor.sv]
// LZ10 stream decompressor
// req channel: one compressed byte per beat in req_tdata, header bytes included.
//   req_tuser high marks the version byte of a new stream and restarts parsing.
// rsp channel: one decompressed byte per beat in rsp_tdata. rsp_tlast marks the
//   final beat caused by one input byte; rsp_tuser[0] marks the beat that
//   reaches the declared size, rsp_tuser[2:1] carries an error code (bad
//   version, distance before stream start); error beats carry zero data.
// A parser takes one input beat per cycle while the queue is not full and
// pushes literal, copy or error commands into a four-entry queue; an executor
// drains it into the history memory and the output register. A copy of n
// bytes does one history read per byte, and a back-reference pair copies at
// most 18 bytes. Reset returns the parser to waiting for a start beat and
// empties the queue; the history memory is not cleared, as only bytes of the
// current stream are read. When the receiver stalls, the output register
// holds its beat, the executor stops and the queue fills, after which
// req_tready drops.
module lz10_stream_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // start_req
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic [2:0] rsp_tuser    // done_res, error[1:0]
);
   import lz10_pkg::*;

   fifo_status_type fifo_status;
   cmd_type         push_cmd;
   cmd_type         head_cmd;
   logic            push;
   logic            pop;

   // parser
   lz10_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .fifo_status (fifo_status),
      .cmd_push    (push),
      .cmd         (push_cmd)
   );

   // command queue
   lz10_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (fifo_status)
   );

   // executor
   lz10_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

[design/lz10_checker.sv]
module lz10_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [2:0] rsp_tuser
);
   import lz10_pkg::*;

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat shown after reset");

   // a stalled beat stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // error beats close the run with zero data and no done mark
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] != ERR_NONE |->
         rsp_tdata == 8'h00 && rsp_tlast && !rsp_tuser[0])
      else $error("malformed error beat");

   // reaching the declared size always ends a run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("done beat without tlast");

   // only defined error codes appear
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] == ERR_NONE || rsp_tuser[2:1] == ERR_VERSION ||
         rsp_tuser[2:1] == ERR_DISTANCE)
      else $error("undefined error code");

endmodule

bind lz10_stream_decompressor lz10_checker u_checker (.*);
